### design/kmst_pkg.sv
package kmst_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int MAX_EDGES    = 256;
	localparam int WEIGHT_BITS  = 16;

	localparam int VID_W  = $clog2(MAX_VERTICES);
	localparam int VCNT_W = 7;
	localparam int EIDX_W = $clog2(MAX_EDGES);
	localparam int ECNT_W = EIDX_W + 1;
	localparam int RANK_W = 3;

	typedef struct packed {
		logic [VID_W-1:0]              src;
		logic [VID_W-1:0]              dst;
		logic signed [WEIGHT_BITS-1:0] w;
	} edge_t;

	typedef struct packed {
		logic [VID_W-1:0]  par;
		logic [RANK_W-1:0] rank;
	} uf_ent_t;

	typedef struct packed {
		logic store;
		logic start_run;
		logic srch_init;
		logic srch_step;
		logic take;
		logic drop;
		logic find_init;
		logic init_side;
		logic side;
		logic uf_rd;
		logic find_chk;
		logic comp_chk;
		logic join1;
		logic join2;
		logic emit_rd;
		logic emit_ld;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic can_pick;
		logic srch_done;
		logic found;
		logic bad_ends;
		logic p_self;
		logic comp_done;
		logic roots_differ;
		logic ranks_eq;
		logic out_free;
		logic emit_last;
	} sts_t;

endpackage

### design/kmst_ctrl.sv
module kmst_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            edge_valid,
	input  logic            last_edge,
	input  kmst_pkg::sts_t  sts,
	output logic            edge_ready,
	output kmst_pkg::cmd_t  cmd
);
	import kmst_pkg::*;

	typedef enum logic [3:0] {
		IDLE, CHECK, SRCH, RANGE, FIND_RD, FIND_CHK, COMP_RD, COMP_CHK,
		JOIN, JOIN2, EMIT_RD, EMIT_LD
	} state_t;

	state_t state_q, state_d;
	logic   side_q, side_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			side_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			side_q  <= side_d;
		end
	end

	assign edge_ready = (state_q == IDLE);

	always_comb begin
		state_d = state_q;
		side_d  = side_q;
		cmd     = '0;
		cmd.side = side_q;
		case (state_q)
			IDLE: begin
				cmd.store = edge_valid;
				if (edge_valid && last_edge) begin
					cmd.start_run = 1'b1;
					state_d = CHECK;
				end
			end
			CHECK: begin
				if (sts.can_pick) begin
					cmd.srch_init = 1'b1;
					state_d = SRCH;
				end else begin
					state_d = EMIT_RD;
				end
			end
			SRCH: begin
				cmd.srch_step = 1'b1;
				if (sts.srch_done) begin
					if (sts.found) begin
						cmd.take = 1'b1;
						state_d = RANGE;
					end else begin
						state_d = EMIT_RD;
					end
				end
			end
			RANGE: begin
				if (sts.bad_ends) begin
					cmd.drop = 1'b1;
					state_d = CHECK;
				end else begin
					cmd.find_init = 1'b1;
					cmd.init_side = 1'b0;
					side_d = 1'b0;
					state_d = FIND_RD;
				end
			end
			FIND_RD: begin
				cmd.uf_rd = 1'b1;
				state_d = FIND_CHK;
			end
			FIND_CHK: begin
				cmd.find_chk = 1'b1;
				state_d = sts.p_self ? COMP_RD : FIND_RD;
			end
			COMP_RD: begin
				cmd.uf_rd = 1'b1;
				state_d = COMP_CHK;
			end
			COMP_CHK: begin
				cmd.comp_chk = 1'b1;
				if (!sts.comp_done) begin
					state_d = COMP_RD;
				end else if (!side_q) begin
					cmd.find_init = 1'b1;
					cmd.init_side = 1'b1;
					side_d = 1'b1;
					state_d = FIND_RD;
				end else begin
					state_d = JOIN;
				end
			end
			JOIN: begin
				if (sts.roots_differ) begin
					cmd.join1 = 1'b1;
					state_d = sts.ranks_eq ? JOIN2 : CHECK;
				end else begin
					state_d = CHECK;
				end
			end
			JOIN2: begin
				cmd.join2 = 1'b1;
				state_d = CHECK;
			end
			EMIT_RD: begin
				cmd.emit_rd = 1'b1;
				state_d = EMIT_LD;
			end
			EMIT_LD: begin
				if (sts.out_free) begin
					cmd.emit_ld = 1'b1;
					if (sts.emit_last) begin
						cmd.finish = 1'b1;
						state_d = IDLE;
					end else begin
						state_d = EMIT_RD;
					end
				end
			end
			default: state_d = IDLE;
		endcase
	end

endmodule

### design/kmst_dp.sv
module kmst_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	input  logic [kmst_pkg::VCNT_W-1:0]            vertex_count,
	input  logic [kmst_pkg::VID_W-1:0]             edge_src,
	input  logic [kmst_pkg::VID_W-1:0]             edge_dest,
	input  logic signed [kmst_pkg::WEIGHT_BITS-1:0] edge_weight,
	input  logic                                   tree_ready,
	input  kmst_pkg::cmd_t                         cmd,
	output kmst_pkg::sts_t                         sts,
	output logic                                   tree_valid,
	output logic [kmst_pkg::VID_W-1:0]             tree_src,
	output logic [kmst_pkg::VID_W-1:0]             tree_dest,
	output logic signed [kmst_pkg::WEIGHT_BITS-1:0] tree_weight,
	output logic                                   last_result,
	output logic                                   empty_tree,
	output logic                                   edges_dropped
);
	import kmst_pkg::*;

	logic [VCNT_W-1:0] vcnt_q, veff;
	logic [ECNT_W-1:0] ecnt_q, si_q;
	logic              drop_q;
	logic [VID_W-1:0]  picks_q, oi_q;

	// edge store and search pipeline
	edge_t             emem [MAX_EDGES];
	edge_t             erd_q, in_e;
	logic              bad_in, full, e_we;
	logic              s1_vld_q;
	logic [EIDX_W-1:0] s1_idx_q;
	logic              best_vld_q, prev_vld_q;
	edge_t             best_q;
	logic [EIDX_W-1:0] best_idx_q, prev_idx_q;
	logic signed [WEIGHT_BITS-1:0] prev_w_q;
	logic              gt_prev, lt_best, upd;

	// union-find forest
	uf_ent_t           ufm [MAX_VERTICES];
	uf_ent_t           uf_rd_q, uf_wd;
	logic              uf_rv_q, uf_we;
	logic [VID_W-1:0]  uf_wa;
	logic [MAX_VERTICES-1:0] vld_q;
	logic [VID_W-1:0]  v_q, p, roota_q, rootb_q, root_sel;
	logic [RANK_W-1:0] rk, ranka_q, rankb_q;

	// chosen edges
	edge_t             pmem [MAX_VERTICES];
	edge_t             prd_q;
	logic              out_v_q;

	assign veff   = (vcnt_q > VCNT_W'(MAX_VERTICES)) ? VCNT_W'(MAX_VERTICES) : vcnt_q;
	assign in_e   = '{src: edge_src, dst: edge_dest, w: edge_weight};
	assign bad_in = (VCNT_W'(edge_src) >= veff) || (VCNT_W'(edge_dest) >= veff);
	assign full   = (ecnt_q == ECNT_W'(MAX_EDGES));
	assign e_we   = cmd.store && !bad_in && !full;

	assign gt_prev = !prev_vld_q || (erd_q.w > prev_w_q) ||
	                 ((erd_q.w == prev_w_q) && (s1_idx_q > prev_idx_q));
	assign lt_best = !best_vld_q || (erd_q.w < best_q.w);
	assign upd     = s1_vld_q && gt_prev && lt_best;

	assign p        = uf_rv_q ? uf_rd_q.par : v_q;
	assign rk       = uf_rv_q ? uf_rd_q.rank : '0;
	assign root_sel = cmd.side ? rootb_q : roota_q;

	assign sts.can_pick     = ((VCNT_W'(picks_q) + VCNT_W'(1)) < veff);
	assign sts.srch_done    = (si_q >= ecnt_q) && !s1_vld_q;
	assign sts.found        = best_vld_q;
	assign sts.bad_ends     = (VCNT_W'(best_q.src) >= veff) || (VCNT_W'(best_q.dst) >= veff);
	assign sts.p_self       = (p == v_q);
	assign sts.comp_done    = (p == root_sel) || (v_q == root_sel);
	assign sts.roots_differ = (roota_q != rootb_q);
	assign sts.ranks_eq     = (ranka_q == rankb_q);
	assign sts.out_free     = !out_v_q || tree_ready;
	assign sts.emit_last    = (picks_q == '0) || ((oi_q + VID_W'(1)) == picks_q);

	always_comb begin
		uf_we = 1'b0;
		uf_wa = v_q;
		uf_wd = '{par: root_sel, rank: rk};
		if (cmd.comp_chk && !sts.comp_done) begin
			uf_we = 1'b1;
		end else if (cmd.join1) begin
			uf_we = 1'b1;
			if (ranka_q < rankb_q) begin
				uf_wa = roota_q;
				uf_wd = '{par: rootb_q, rank: ranka_q};
			end else begin
				uf_wa = rootb_q;
				uf_wd = '{par: roota_q, rank: rankb_q};
			end
		end else if (cmd.join2) begin
			uf_we = 1'b1;
			uf_wa = roota_q;
			uf_wd = '{par: roota_q, rank: ranka_q + RANK_W'(1)};
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (e_we)
			emem[ecnt_q[EIDX_W-1:0]] <= in_e;
		erd_q <= emem[si_q[EIDX_W-1:0]];
		if (uf_we)
			ufm[uf_wa] <= uf_wd;
		if (cmd.uf_rd) begin
			uf_rd_q <= ufm[v_q];
			uf_rv_q <= vld_q[v_q];
		end
		if (cmd.join1)
			pmem[picks_q] <= best_q;
		if (cmd.emit_rd)
			prd_q <= pmem[oi_q];
	end

	// payload registers
	always_ff @(posedge clk) begin
		s1_idx_q <= si_q[EIDX_W-1:0];
		if (upd) begin
			best_q     <= erd_q;
			best_idx_q <= s1_idx_q;
		end
		if (cmd.take) begin
			prev_w_q   <= best_q.w;
			prev_idx_q <= best_idx_q;
		end
		if (cmd.find_init)
			v_q <= cmd.init_side ? best_q.dst : best_q.src;
		else if (cmd.find_chk) begin
			if (sts.p_self) begin
				if (cmd.side) begin
					rootb_q <= v_q;
					rankb_q <= rk;
				end else begin
					roota_q <= v_q;
					ranka_q <= rk;
				end
				v_q <= cmd.side ? best_q.dst : best_q.src;
			end else begin
				v_q <= p;
			end
		end else if (cmd.comp_chk && !sts.comp_done)
			v_q <= p;
		if (cmd.emit_ld) begin
			if (picks_q == '0) begin
				tree_src    <= '0;
				tree_dest   <= '0;
				tree_weight <= '0;
				last_result <= 1'b1;
				empty_tree  <= 1'b1;
			end else begin
				tree_src    <= prd_q.src;
				tree_dest   <= prd_q.dst;
				tree_weight <= prd_q.w;
				last_result <= sts.emit_last;
				empty_tree  <= 1'b0;
			end
			edges_dropped <= drop_q;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcnt_q     <= VCNT_W'(MAX_VERTICES);
			ecnt_q     <= '0;
			drop_q     <= 1'b0;
			picks_q    <= '0;
			oi_q       <= '0;
			si_q       <= '0;
			s1_vld_q   <= 1'b0;
			best_vld_q <= 1'b0;
			prev_vld_q <= 1'b0;
			vld_q      <= '0;
			out_v_q    <= 1'b0;
		end else begin
			if (cfg_valid)
				vcnt_q <= vertex_count;
			if (e_we)
				ecnt_q <= ecnt_q + ECNT_W'(1);
			if (cmd.store && !e_we)
				drop_q <= 1'b1;
			if (cmd.drop)
				drop_q <= 1'b1;
			if (cmd.start_run) begin
				vld_q      <= '0;
				prev_vld_q <= 1'b0;
			end else if (uf_we)
				vld_q[uf_wa] <= 1'b1;
			if (cmd.srch_init) begin
				si_q       <= '0;
				best_vld_q <= 1'b0;
			end else if (cmd.srch_step && (si_q < ecnt_q))
				si_q <= si_q + ECNT_W'(1);
			s1_vld_q <= cmd.srch_step && (si_q < ecnt_q);
			if (upd)
				best_vld_q <= 1'b1;
			if (cmd.take)
				prev_vld_q <= 1'b1;
			if (cmd.join1)
				picks_q <= picks_q + VID_W'(1);
			if (cmd.emit_ld) begin
				out_v_q <= 1'b1;
				oi_q    <= oi_q + VID_W'(1);
			end else if (tree_ready)
				out_v_q <= 1'b0;
			if (cmd.finish) begin
				ecnt_q  <= '0;
				drop_q  <= 1'b0;
				picks_q <= '0;
				oi_q    <= '0;
			end
		end
	end

	assign tree_valid = out_v_q;

endmodule

### design/kruskal_min_spanning_tree.sv
// Minimum spanning tree engine (Kruskal, union-find with union by rank and
// path compression) over a streamed edge list.
// Edge channel: edge_valid/edge_ready carry one edge per transaction; one
// edge is taken per cycle while the block is loading. The transaction with
// last_edge set starts the run, and edge_ready stays low until every result
// of that run has been handed to the output register.
// Result channel: tree_valid/tree_ready carry one chosen edge per
// transaction, in ascending weight order; last_result marks the final one,
// and a run with no chosen edge gives a single result with empty_tree set.
// Config channel: cfg_valid/cfg_ready write vertex_count; write it only while
// the block is idle. cfg_ready is always high.
// Selection: each selection step scans the whole edge store through its single
// read port; each union-find lookup reads and then checks one entry per tree
// level walked, and each result is read from the chosen-edge store and then
// loaded into the output register.
// Reset: vertex_count returns to 64 and the edge list is emptied.
// A stalled receiver holds the result in the output register; the next run
// may load edges while the final result of a run still waits.
module kruskal_min_spanning_tree (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [kmst_pkg::VCNT_W-1:0]            vertex_count,
	input  logic                                   edge_valid,
	output logic                                   edge_ready,
	input  logic [kmst_pkg::VID_W-1:0]             edge_src,
	input  logic [kmst_pkg::VID_W-1:0]             edge_dest,
	input  logic signed [kmst_pkg::WEIGHT_BITS-1:0] edge_weight,
	input  logic                                   last_edge,
	output logic                                   tree_valid,
	input  logic                                   tree_ready,
	output logic [kmst_pkg::VID_W-1:0]             tree_src,
	output logic [kmst_pkg::VID_W-1:0]             tree_dest,
	output logic signed [kmst_pkg::WEIGHT_BITS-1:0] tree_weight,
	output logic                                   last_result,
	output logic                                   empty_tree,
	output logic                                   edges_dropped
);
	import kmst_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	kmst_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.edge_valid (edge_valid),
		.last_edge  (last_edge),
		.sts        (sts),
		.edge_ready (edge_ready),
		.cmd        (cmd)
	);

	kmst_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.vertex_count  (vertex_count),
		.edge_src      (edge_src),
		.edge_dest     (edge_dest),
		.edge_weight   (edge_weight),
		.tree_ready    (tree_ready),
		.cmd           (cmd),
		.sts           (sts),
		.tree_valid    (tree_valid),
		.tree_src      (tree_src),
		.tree_dest     (tree_dest),
		.tree_weight   (tree_weight),
		.last_result   (last_result),
		.empty_tree    (empty_tree),
		.edges_dropped (edges_dropped)
	);

endmodule

### tb/sv/tb_kruskal_min_spanning_tree.sv
`timescale 1ns / 1ps

module tb_kruskal_min_spanning_tree;
	import kmst_pkg::*;

	typedef struct packed {
		logic [VID_W-1:0]              src;
		logic [VID_W-1:0]              dst;
		logic signed [WEIGHT_BITS-1:0] w;
		logic                          last;
		logic                          empty;
		logic                          dropped;
	} tree_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [VCNT_W-1:0] vertex_count = 7'd64;
	logic edge_valid = 1'b0;
	logic edge_ready;
	logic [VID_W-1:0] edge_src = '0;
	logic [VID_W-1:0] edge_dest = '0;
	logic signed [WEIGHT_BITS-1:0] edge_weight = '0;
	logic last_edge = 1'b0;
	logic tree_valid;
	logic tree_ready = 1'b0;
	logic [VID_W-1:0] tree_src;
	logic [VID_W-1:0] tree_dest;
	logic signed [WEIGHT_BITS-1:0] tree_weight;
	logic last_result;
	logic empty_tree;
	logic edges_dropped;

	kruskal_min_spanning_tree u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .vertex_count(vertex_count),
		.edge_valid(edge_valid), .edge_ready(edge_ready), .edge_src(edge_src),
		.edge_dest(edge_dest), .edge_weight(edge_weight), .last_edge(last_edge),
		.tree_valid(tree_valid), .tree_ready(tree_ready), .tree_src(tree_src),
		.tree_dest(tree_dest), .tree_weight(tree_weight), .last_result(last_result),
		.empty_tree(empty_tree), .edges_dropped(edges_dropped)
	);

	always #2 clk = ~clk;

	// mirror of the block state
	int unsigned vcount_m = 64;
	edge_t graph_edges[$];
	bit dropped_m;
	int unsigned parent_m[MAX_VERTICES];
	int unsigned rank_m[MAX_VERTICES];

	tree_res_t tree_expect[$];
	int errors = 0;
	int edges_sent = 0;
	int results_seen = 0;
	int runs_done = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	event long_hold;
	bit hold_on = 1'b0;

	function automatic int unsigned root_of(int unsigned v);
		int unsigned r;
		int unsigned nx;
		r = v;
		while (parent_m[r] != r) r = parent_m[r];
		while (parent_m[v] != r) begin
			nx = parent_m[v];
			parent_m[v] = r;
			v = nx;
		end
		return r;
	endfunction

	// store the edge and, on the last one, compute the spanning tree
	function automatic void predict_tree(edge_t e, bit last);
		int unsigned nv;
		int unsigned picks;
		int unsigned xr, yr;
		edge_t sorted[$];
		tree_res_t run_res[$];
		tree_res_t r;
		int k;
		nv = (vcount_m > MAX_VERTICES) ? MAX_VERTICES : vcount_m;
		if (e.src >= nv || e.dst >= nv || graph_edges.size() >= MAX_EDGES)
			dropped_m = 1'b1;
		else
			graph_edges.push_back(e);
		if (!last) return;
		// stable insertion sort by signed weight
		foreach (graph_edges[i]) begin
			k = sorted.size();
			while (k > 0 && sorted[k-1].w > graph_edges[i].w) k--;
			sorted.insert(k, graph_edges[i]);
		end
		for (int v = 0; v < MAX_VERTICES; v++) begin
			parent_m[v] = v;
			rank_m[v] = 0;
		end
		picks = 0;
		foreach (sorted[i]) begin
			if (nv == 0 || picks + 1 >= nv) break;
			if (sorted[i].src >= nv || sorted[i].dst >= nv) begin
				dropped_m = 1'b1;
				continue;
			end
			xr = root_of(sorted[i].src);
			yr = root_of(sorted[i].dst);
			if (xr != yr) begin
				r = '0;
				r.src = sorted[i].src;
				r.dst = sorted[i].dst;
				r.w = sorted[i].w;
				run_res.push_back(r);
				picks++;
				if (rank_m[xr] < rank_m[yr]) parent_m[xr] = yr;
				else if (rank_m[xr] > rank_m[yr]) parent_m[yr] = xr;
				else begin
					parent_m[yr] = xr;
					rank_m[xr]++;
				end
			end
		end
		if (run_res.size() == 0) begin
			r = '0;
			r.last = 1'b1;
			r.empty = 1'b1;
			run_res.push_back(r);
		end
		run_res[run_res.size()-1].last = 1'b1;
		foreach (run_res[i]) begin
			run_res[i].dropped = dropped_m;
			tree_expect.push_back(run_res[i]);
		end
		graph_edges.delete();
		dropped_m = 1'b0;
		runs_done++;
	endfunction

	// returns at the accepting edge with valid still high; at the following falling
	// edge the next call drops it or drives a new edge, and drain_results drops it
	task automatic send_edge(int s, int d, int w, bit last);
		edge_t e;
		@(negedge clk);
		while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
			edge_valid <= 1'b0;
			@(negedge clk);
		end
		edge_valid  <= 1'b1;
		edge_src    <= VID_W'(s);
		edge_dest   <= VID_W'(d);
		edge_weight <= WEIGHT_BITS'(w);
		last_edge   <= last;
		@(posedge clk);
		while (!edge_ready) @(posedge clk);
		e.src = VID_W'(s);
		e.dst = VID_W'(d);
		e.w = WEIGHT_BITS'(w);
		predict_tree(e, last);
		edges_sent++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		edge_valid <= 1'b0;
		while (tree_expect.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_vertex_count(int n);
		drain_results();
		cfg_valid <= 1'b1;
		vertex_count <= VCNT_W'(n);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		vcount_m = n;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// long receiver hold, counted in cycles
	always begin
		@(long_hold);
		hold_on = 1'b1;
		repeat (400) @(posedge clk);
		hold_on = 1'b0;
	end

	// receiver side
	always @(negedge clk) begin
		if (hold_on)
			tree_ready <= 1'b0;
		else
			tree_ready <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && tree_valid && tree_ready) begin
			tree_res_t exp_r;
			results_seen++;
			if (tree_expect.size() == 0) begin
				$error("unexpected result src=%0d dest=%0d", tree_src, tree_dest);
				errors++;
			end else begin
				exp_r = tree_expect.pop_front();
				if (tree_src !== exp_r.src) begin
					$error("tree_src exp %0d got %0d", exp_r.src, tree_src); errors++;
				end
				if (tree_dest !== exp_r.dst) begin
					$error("tree_dest exp %0d got %0d", exp_r.dst, tree_dest); errors++;
				end
				if (tree_weight !== exp_r.w) begin
					$error("tree_weight exp %0d got %0d", exp_r.w, tree_weight); errors++;
				end
				if (last_result !== exp_r.last) begin
					$error("last_result exp %0d got %0d", exp_r.last, last_result); errors++;
				end
				if (empty_tree !== exp_r.empty) begin
					$error("empty_tree exp %0d got %0d", exp_r.empty, empty_tree); errors++;
				end
				if (edges_dropped !== exp_r.dropped) begin
					$error("edges_dropped exp %0d got %0d", exp_r.dropped, edges_dropped);
					errors++;
				end
			end
		end
	end

	task automatic random_graph(int nedges, int vmax, int bad_pct);
		int s, d;
		for (int i = 0; i < nedges; i++) begin
			s = $urandom_range(vmax, 0);
			d = $urandom_range(vmax, 0);
			if ($urandom_range(99, 0) < bad_pct) s = $urandom_range(63, 0);
			send_edge(s, d, $urandom_range(65535, 0), i == nedges - 1);
		end
	endtask

	task automatic test_directed();
		// extreme weights, ties, self loop, cycle
		send_edge(0, 1, 32767, 0);
		send_edge(1, 2, -32768, 0);
		send_edge(2, 2, -5, 0);
		send_edge(0, 2, 7, 0);
		send_edge(2, 0, 7, 0);
		send_edge(63, 0, 7, 0);
		send_edge(62, 63, 0, 1);
		// self loop only: empty tree
		send_edge(5, 5, 1, 1);
		// bad endpoint with vertex_count lowered
		write_vertex_count(4);
		send_edge(3, 4, 1, 0);
		send_edge(0, 3, 2, 0);
		send_edge(4, 0, 3, 1);
		// vertex_count zero drops all
		write_vertex_count(0);
		send_edge(0, 0, 1, 1);
		// above MAX saturates
		write_vertex_count(127);
		send_edge(63, 62, 10, 0);
		send_edge(42, 21, -1, 1);
		// single vertex: never picks
		write_vertex_count(1);
		send_edge(0, 0, 3, 1);
		// lowered after storing: stored edge dropped after selection
		write_vertex_count(64);
		send_edge(40, 1, -9, 0);
		send_edge(0, 1, 4, 0);
		drain_results();
		cfg_valid <= 1'b1;
		vertex_count <= 7'd2;
		@(posedge clk);
		vcount_m = 2;
		@(negedge clk);
		cfg_valid <= 1'b0;
		send_edge(1, 0, 5, 1);
	endtask

	task automatic test_capacity();
		write_vertex_count(8);
		for (int i = 0; i < MAX_EDGES + 3; i++)
			send_edge($urandom_range(7, 0), $urandom_range(7, 0),
				$urandom_range(65535, 0), 0);
		send_edge(1, 2, 0, 1);
	endtask

	task automatic test_random_phases();
		int cfgs[4] = '{64, 2, 16, 33};
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
				default: begin send_idle_pct = 28; recv_stall_pct = 28; end
			endcase
			write_vertex_count(cfgs[p]);
			for (int g = 0; g < 2; g++)
				random_graph($urandom_range(7, 1), cfgs[p] - 1, 8);
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	task automatic test_back_pressure();
		write_vertex_count(64);
		-> long_hold;
		for (int g = 0; g < 3; g++) random_graph(8, 63, 0);
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random_phases();
		test_back_pressure();
		test_capacity();
		drain_results();
		$display("Sent %0d edges over %0d runs, checked %0d tree results.",
			edges_sent, runs_done, results_seen);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#4000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
